// ===== design/vvh_pkg.sv =====
// ----------------------------------------------------------------------------
// vvh_pkg: shared types and constants of the voxel visit histogram
// Holds the item payload types, register indexes and states.
// ----------------------------------------------------------------------------
package vvh_pkg;

  localparam int GridEdgeDef  = 16;
  localparam int GridHalfDef  = 8;
  localparam int CountBitsDef = 16;

  localparam logic [9:0]  CellSizeRst  = 10'd100;
  localparam logic [11:0] YOffsetRst   = 12'd1000;
  localparam logic [12:0] ReachableRst = 13'd0;

  localparam logic [1:0] RegCellSize  = 2'd0;
  localparam logic [1:0] RegYOffset   = 2'd1;
  localparam logic [1:0] RegReachable = 2'd2;

  localparam logic ActRecord = 1'b0;
  localparam logic ActClear  = 1'b1;

  typedef struct packed {
    logic              action;
    logic              hand;
    logic signed [15:0] hand_x;
    logic signed [15:0] hand_y;
    logic signed [15:0] hand_z;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic signed [15:0] head_z;
  } in_item_t;

  typedef struct packed {
    logic        in_range;
    logic        new_cell;
    logic [12:0] unique_cells;
    logic [31:0] left_total;
    logic [31:0] right_total;
    logic [18:0] coverage_pct;
    logic [6:0]  symmetry_pct;
  } out_item_t;

  // Front stage states: divide three axes one after the other.
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  // Back stage states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_UPDATE,
    BK_COV,
    BK_SYM,
    BK_OUT
  } back_state_e;

endpackage

// ===== design/vvh_if.sv =====
// ----------------------------------------------------------------------------
// vvh_if: valid/ready channel
// Carries one item of payload type T between a source and a sink.
// ----------------------------------------------------------------------------
interface vvh_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/vvh_front.sv =====
// ----------------------------------------------------------------------------
// vvh_front: classify stage
// Accepts items, forms relative positions and quantizes each axis with one
// shared restoring divider, then hands the cell index to the queue.
// ----------------------------------------------------------------------------
module vvh_front #(
  parameter int GridEdge = vvh_pkg::GridEdgeDef,
  parameter int GridHalf = vvh_pkg::GridHalfDef,
  localparam int IdxBits = 3 * $clog2(GridEdge)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vvh_pkg::in_item_t    in_data_i,
  input  logic [9:0]           cell_size_i,
  input  logic [11:0]          y_offset_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic [IdxBits+2:0]   q_data_o   // {action, hand, in range, index}
);
  import vvh_pkg::*;

  localparam int AxBits = $clog2(GridEdge);
  localparam int QBits  = 19;  // magnitude 2|v|+c below 2^19

  front_state_e state_q, state_d;
  logic [1:0]  axis_q, axis_d;
  logic [4:0]  step_q, step_d;
  logic [QBits-1:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [2:0]  neg_q, neg_d;
  logic [2:0][17:0] mag_q, mag_d;
  logic [2:0][QBits-1:0] res_q, res_d;
  logic        act_q, act_d, hand_q, hand_d;
  logic [10:0] dvs;
  logic [QBits:0] trial;
  logic signed [18:0] rel [3];
  logic signed [QBits+1:0] sq [3];
  logic [2:0]  ok;
  logic [2:0][AxBits-1:0] ax;

  // Divisor is twice the cell size; zero size counts as one.
  assign dvs = (cell_size_i == 10'd0) ? 11'd2 : {cell_size_i, 1'b0};

  always_comb begin
    rel[0] = 19'(in_data_i.hand_x) - 19'(in_data_i.head_x);
    rel[1] = 19'(in_data_i.hand_y) - 19'(in_data_i.head_y) + $signed({7'd0, y_offset_i});
    rel[2] = 19'(in_data_i.hand_z) - 19'(in_data_i.head_z);
  end

  assign trial = {rem_q, num_q[QBits-1]} - {{(QBits-10){1'b0}}, dvs};

  // Sign-applied quotients; x and z are shifted by half the grid into grid coordinates.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq[a] = neg_q[a] ? -$signed({2'b00, res_q[a]}) : $signed({2'b00, res_q[a]});
      if (a != 1) sq[a] = sq[a] + (QBits+2)'(GridHalf);
      ok[a] = (sq[a] >= 0) && (sq[a] < (QBits+2)'(GridEdge));
      ax[a] = sq[a][AxBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q <= axis_d; step_q <= step_d; rem_q <= rem_d; quo_q <= quo_d;
    num_q <= num_d; neg_q <= neg_d; mag_q <= mag_d; res_q <= res_d;
    act_q <= act_d; hand_q <= hand_d;
  end

  // Sequencer: one quotient bit per cycle, axes in turn.
  always_comb begin
    state_d = state_q; axis_d = axis_q; step_d = step_q; rem_d = rem_q;
    quo_d = quo_q; num_d = num_q; neg_d = neg_q; mag_d = mag_q; res_d = res_q;
    act_d = act_q; hand_d = hand_q;
    in_ready_o = 1'b0;
    q_valid_o  = 1'b0;
    case (state_q)
      FR_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d = in_data_i.action;
          hand_d = in_data_i.hand;
          for (int a = 0; a < 3; a++) begin
            neg_d[a] = rel[a][18];
            mag_d[a] = rel[a][18] ? 18'(-rel[a]) : 18'(rel[a]);
          end
          axis_d = 2'd0; step_d = 5'd0;
          rem_d = '0; quo_d = '0;
          num_d = {mag_d[0], 1'b0} + QBits'(dvs[10:1]);
          state_d = (in_data_i.action == ActClear) ? FR_PUSH : FR_DIV;
        end
      end
      FR_DIV: begin
        if (!trial[QBits]) begin
          rem_d = trial[QBits-1:0];
          quo_d = {quo_q[QBits-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[QBits-2:0], num_q[QBits-1]};
          quo_d = {quo_q[QBits-2:0], 1'b0};
        end
        num_d = {num_q[QBits-2:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'(QBits-1)) begin
          res_d[axis_q] = quo_d;
          rem_d = '0; quo_d = '0; step_d = 5'd0;
          if (axis_q == 2'd2) begin
            state_d = FR_PUSH;
          end else begin
            axis_d = axis_q + 2'd1;
            num_d = {mag_q[axis_d], 1'b0} + QBits'(dvs[10:1]);
          end
        end
      end
      FR_PUSH: begin
        q_valid_o = 1'b1;
        if (q_ready_i) state_d = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign q_data_o = {act_q, hand_q, (act_q == ActRecord) && (&ok), ax[2], ax[1], ax[0]};
endmodule

// ===== design/vvh_fifo.sv =====
// ----------------------------------------------------------------------------
// vvh_fifo: small queue between the front and back stages
// Two entries, valid/ready on both sides.
// ----------------------------------------------------------------------------
module vvh_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             w_valid_i,
  output logic             w_ready_o,
  input  logic [Width-1:0] w_data_i,
  output logic             r_valid_o,
  input  logic             r_ready_i,
  output logic [Width-1:0] r_data_o
);
  logic [1:0][Width-1:0] mem_q;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign w_ready_o = cnt_q != 2'd2;
  assign r_valid_o = cnt_q != 2'd0;
  assign r_data_o  = mem_q[rp_q];
  assign wr = w_valid_i && w_ready_o;
  assign rd = r_valid_o && r_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= w_data_i;
  end
endmodule

// ===== design/vvh_back.sv =====
// ----------------------------------------------------------------------------
// vvh_back: update stage
// Reads and writes the cell store, keeps totals, and works out coverage and
// symmetry with one shared serial divider; holds the result until taken.
// ----------------------------------------------------------------------------
module vvh_back #(
  parameter int GridEdge  = vvh_pkg::GridEdgeDef,
  parameter int CountBits = vvh_pkg::CountBitsDef,
  localparam int IdxBits  = 3 * $clog2(GridEdge)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  logic [IdxBits+2:0] q_data_i,
  input  logic [12:0]        reachable_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vvh_pkg::out_item_t out_data_o
);
  import vvh_pkg::*;

  localparam int Depth = 1 << IdxBits;
  localparam logic [CountBits-1:0] CntMax = '1;
  localparam int DBits = 39;  // dividend up to 32-bit total times 100

  back_state_e state_q, state_d;
  logic [2*CountBits-1:0] mem [Depth];
  logic [2*CountBits-1:0] rd_q, wdat;
  logic                   we;
  logic [IdxBits-1:0]     idx_q, idx_d, waddr;
  logic                   clr_q, clr_d;   // clearing pass after reset running
  logic [12:0]  visit_q, visit_d;
  logic [31:0]  left_q, left_d, right_q, right_d;
  logic         inr_q, inr_d, new_q, new_d, hand_q, hand_d;
  logic [18:0]  cov_q, cov_d;
  logic [6:0]   sym_q, sym_d;
  logic [DBits-1:0] num_q, num_d, quo_q, quo_d;
  logic [32:0]  rem_q, rem_d;
  logic [31:0]  den_q, den_d;
  logic [5:0]   step_q, step_d;
  logic [33:0]  trial;
  logic [CountBits-1:0] cl, cr;
  logic [31:0]  lo, hi;

  assign cl = rd_q[CountBits-1:0];
  assign cr = rd_q[2*CountBits-1:CountBits];
  assign lo = (left_q < right_q) ? left_q : right_q;
  assign hi = (left_q < right_q) ? right_q : left_q;
  assign trial = {rem_q, num_q[DBits-1]} - {2'b00, den_q};

  // Cell store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdat;
    rd_q <= mem[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR; idx_q <= '0; clr_q <= 1'b1;
      visit_q <= '0; left_q <= '0; right_q <= '0; step_q <= '0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; clr_q <= clr_d;
      visit_q <= visit_d; left_q <= left_d; right_q <= right_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inr_q <= inr_d; new_q <= new_d; hand_q <= hand_d; cov_q <= cov_d;
    sym_q <= sym_d; num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d;
    den_q <= den_d;
  end

  always_comb begin
    state_d = state_q; idx_d = idx_q; clr_d = clr_q;
    visit_d = visit_q; left_d = left_q; right_d = right_q;
    inr_d = inr_q; new_d = new_q; hand_d = hand_q; cov_d = cov_q; sym_d = sym_q;
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q; step_d = step_q;
    we = 1'b0; waddr = idx_q; wdat = '0;
    q_ready_o = 1'b0; out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          hand_d = q_data_i[IdxBits+1];
          inr_d  = q_data_i[IdxBits];
          idx_d  = q_data_i[IdxBits-1:0];
          new_d  = 1'b0;
          if (q_data_i[IdxBits+2] == ActClear) begin
            idx_d = '0;
            visit_d = '0; left_d = '0; right_d = '0;
            state_d = BK_CLEAR;
          end else begin
            state_d = inr_d ? BK_READ : BK_COV;
          end
        end
      end
      // Clearing pass over the store, one entry a cycle. The pass after
      // reset has no item to report and returns to idle.
      BK_CLEAR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxBits'(Depth-1)) begin
          clr_d = 1'b0;
          state_d = clr_q ? BK_IDLE : BK_COV;
        end
      end
      BK_READ: state_d = BK_UPDATE;
      BK_UPDATE: begin
        we = 1'b1;
        wdat = rd_q;
        new_d = (cl == '0) && (cr == '0);
        if (new_d && visit_q != 13'h1FFF) visit_d = visit_q + 13'd1;
        if (hand_q) begin
          if (cr != CntMax) wdat[2*CountBits-1:CountBits] = cr + 1'b1;
          if (right_q != '1) right_d = right_q + 32'd1;
        end else begin
          if (cl != CntMax) wdat[CountBits-1:0] = cl + 1'b1;
          if (left_q != '1) left_d = left_q + 32'd1;
        end
        state_d = BK_COV;
      end
      BK_COV: begin
        // Load or run the coverage division.
        if (step_q == 6'd0) begin
          num_d = DBits'(visit_q) * DBits'(100);
          den_d = {19'd0, reachable_i};
          rem_d = '0; quo_d = '0; step_d = 6'd1;
        end else begin
          if (!trial[33]) begin
            rem_d = trial[32:0]; quo_d = {quo_q[DBits-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[31:0], num_q[DBits-1]}; quo_d = {quo_q[DBits-2:0], 1'b0};
          end
          num_d = {num_q[DBits-2:0], 1'b0};
          step_d = step_q + 6'd1;
          if (step_q == 6'(DBits)) begin
            if (den_q == '0) cov_d = '0;
            else cov_d = (quo_d > DBits'(19'h7FFFF)) ? 19'h7FFFF : quo_d[18:0];
            step_d = 6'd0;
            state_d = BK_SYM;
          end
        end
      end
      BK_SYM: begin
        if (step_q == 6'd0) begin
          num_d = DBits'(lo) * DBits'(100);
          den_d = hi;
          rem_d = '0; quo_d = '0; step_d = 6'd1;
        end else begin
          if (!trial[33]) begin
            rem_d = trial[32:0]; quo_d = {quo_q[DBits-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[31:0], num_q[DBits-1]}; quo_d = {quo_q[DBits-2:0], 1'b0};
          end
          num_d = {num_q[DBits-2:0], 1'b0};
          step_d = step_q + 6'd1;
          if (step_q == 6'(DBits)) begin
            sym_d = (den_q == '0) ? 7'd100 : quo_d[6:0];
            step_d = 6'd0;
            state_d = BK_OUT;
          end
        end
      end
      BK_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign out_data_o = '{in_range: inr_q, new_cell: new_q, unique_cells: visit_q,
                        left_total: left_q, right_total: right_q,
                        coverage_pct: cov_q, symmetry_pct: sym_q};
endmodule

// ===== design/voxel_visit_histogram.sv =====
// ----------------------------------------------------------------------------
// voxel_visit_histogram: per-hand 3D occupancy histogram
// Front stage quantizes positions, a queue decouples it from the back stage
// that updates the cell store and computes the statistics.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_ch     sink       action, hand, hand_x/y/z, head_x/y/z
// out_ch    source     in_range, new_cell, unique_cells, totals, percentages
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// For each record the front accepts the item, runs three 19-step divisions
// and hands off the cell index; a clear skips the divisions. The back runs
// two 39-step serial divisions per item, after reading and updating the
// store for a record in the grid; a clear first writes one cell per cycle
// (4096 at default size). After reset a clearing pass over all 4096 cells
// runs before results flow. A stalled output holds the back; the queue keeps the front working.
// ----------------------------------------------------------------------------
module voxel_visit_histogram #(
  parameter int GridEdge  = vvh_pkg::GridEdgeDef,
  parameter int GridHalf  = vvh_pkg::GridHalfDef,
  parameter int CountBits = vvh_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vvh_if.sink         in_ch,
  vvh_if.source       out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import vvh_pkg::*;

  localparam int IdxBits = 3 * $clog2(GridEdge);

  logic [9:0]  cell_size_q;
  logic [11:0] y_offset_q;
  logic [12:0] reach_q;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  logic [IdxBits+2:0] fq_data, bq_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CellSizeRst; y_offset_q <= YOffsetRst; reach_q <= ReachableRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCellSize:  cell_size_q <= cfg_data_i[9:0];
        RegYOffset:   y_offset_q  <= cfg_data_i[11:0];
        RegReachable: reach_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vvh_front #(.GridEdge(GridEdge), .GridHalf(GridHalf)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_data_i(in_ch.data),
    .cell_size_i(cell_size_q), .y_offset_i(y_offset_q),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_data_o(fq_data)
  );

  vvh_fifo #(.Width(IdxBits + 3)) u_fifo (
    .clk_i, .rst_ni,
    .w_valid_i(fq_valid), .w_ready_o(fq_ready), .w_data_i(fq_data),
    .r_valid_o(bq_valid), .r_ready_i(bq_ready), .r_data_o(bq_data)
  );

  vvh_back #(.GridEdge(GridEdge), .CountBits(CountBits)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(bq_valid), .q_ready_o(bq_ready), .q_data_i(bq_data),
    .reachable_i(reach_q),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.data)
  );
endmodule

// ===== design/vvh_checker.sv =====
// ----------------------------------------------------------------------------
// vvh_checker: port-level checks of the histogram
// Watches the output channel for stable results and consistent statistics.
// ----------------------------------------------------------------------------
module vvh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input vvh_pkg::out_item_t out_data
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new cell is always in range.
  a_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.new_cell |-> out_data.in_range)
    else $error("new cell outside grid");

  // Symmetry never exceeds one hundred.
  a_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.symmetry_pct <= 7'd100)
    else $error("symmetry above 100");

  // Both totals zero means full symmetry.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.left_total == 0 && out_data.right_total == 0
      |-> out_data.symmetry_pct == 7'd100)
    else $error("empty totals not symmetric");
endmodule

bind voxel_visit_histogram vvh_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);
